// File: hw/rtl/b64enc_pkg.sv
// Package for the base64 stream encoder: the group record that passes from
// the byte gatherer to the character serialiser, and the alphabet lookup.
// No dependencies.
package b64enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] PAD_CHAR = 8'd61;   // '='

    // Number of pad characters that end a group.
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } t_pads;

    // Position of a character within its group of four.
    typedef enum logic [1:0] {
        POS_0 = 2'd0,
        POS_1 = 2'd1,
        POS_2 = 2'd2,
        POS_3 = 2'd3
    } t_pos;

    // One 24-bit group, zero-filled when short, with its padding and end mark.
    typedef struct packed {
        logic [23:0] data;
        t_pads       pads;
        logic        last;
    } t_group;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};          // 'a' - 26
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;           // '0' - 52
        end else if (v == 6'd62) begin
            c = 8'd43;                       // '+'
        end else begin
            c = 8'd47;                       // '/'
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/b64enc_front.sv
// Front end of the base64 encoder: accepts message bytes, gathers them into
// three-byte groups and writes each finished group into the group queue.
// Depends on b64enc_pkg.
module b64enc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_final_byte,
    input  logic                  i_queue_full,
    output logic                  o_queue_push,
    output b64enc_pkg::t_group    o_group
);

    logic [15:0] r_pending;
    logic [15:0] n_pending;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        accept;
    logic        count_two;
    logic        emit;

    assign accept    = i_push && !i_queue_full;
    // A count of three cannot arise; it is handled as two.
    assign count_two = r_count[1];
    assign emit      = accept && (i_final_byte || count_two);

    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        if (emit) begin
            n_pending = 16'h0000;
            n_count   = 2'd0;
        end else if (accept) begin
            if (r_count == 2'd0) begin
                n_pending = {i_data_byte, 8'h00};
            end else begin
                n_pending = {r_pending[15:8], i_data_byte};
            end
            n_count = r_count + 2'd1;
        end
    end

    always_comb begin
        o_group.last = i_final_byte;
        if (count_two) begin
            o_group.data = {r_pending, i_data_byte};
            o_group.pads = b64enc_pkg::PAD_NONE;
        end else if (r_count == 2'd1) begin
            o_group.data = {r_pending[15:8], i_data_byte, 8'h00};
            o_group.pads = b64enc_pkg::PAD_ONE;
        end else begin
            o_group.data = {i_data_byte, 16'h0000};
            o_group.pads = b64enc_pkg::PAD_TWO;
        end
    end

    assign o_queue_push = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 16'h0000;
            r_count   <= 2'd0;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("pending count reached three");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_count == 2'd0 && r_pending == 16'h0000))
        else $error("pending bytes not cleared after a group");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_queue_full |-> !o_queue_push)
        else $error("group written into a full queue");
`endif

endmodule

// File: hw/rtl/b64enc_queue.sv
// Short group queue between the front end and the serialiser, built as a
// shifting register line whose oldest entry always sits in the first slot.
// Depends on b64enc_pkg.
module b64enc_queue #(
    parameter int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64enc_pkg::t_group    i_group,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output b64enc_pkg::t_group    o_head
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64enc_pkg::t_group r_slot [DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      wr_place;
    logic               do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_head   = r_slot[0];
    assign do_pop   = i_pop && !o_empty;
    assign wr_place = r_count - CW'(do_pop);
    assign n_count  = r_count + CW'(i_push) - CW'(do_pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < int'(DEPTH); i++) begin
            if (i_push && wr_place == CW'(i)) begin
                r_slot[i] <= i_group;
            end else if (do_pop && i < int'(DEPTH) - 1) begin
                r_slot[i] <= r_slot[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy beyond its depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");
`endif

endmodule

// File: hw/rtl/b64enc_back.sv
// Back end of the base64 encoder: takes groups from the queue and sends out
// their four characters, one per cycle unless the receiver stalls, through a
// registered output stage. Depends on b64enc_pkg.
module b64enc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_queue_empty,
    input  b64enc_pkg::t_group    i_head,
    output logic                  o_queue_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_char,
    output logic                  o_end_of_message
);

    b64enc_pkg::t_group r_group;
    b64enc_pkg::t_pos   r_pos;
    logic               r_busy;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_eom;
    logic               out_load;
    logic               group_done;
    logic [5:0]         sextet;
    logic               is_pad;
    logic [7:0]         next_char;

    assign out_load    = r_busy && (!r_out_valid || i_pop);
    assign group_done  = out_load && (r_pos == b64enc_pkg::POS_3);
    assign o_queue_pop = !i_queue_empty && (!r_busy || group_done);

    always_comb begin
        case (r_pos)
            b64enc_pkg::POS_0: sextet = r_group.data[23:18];
            b64enc_pkg::POS_1: sextet = r_group.data[17:12];
            b64enc_pkg::POS_2: sextet = r_group.data[11:6];
            b64enc_pkg::POS_3: sextet = r_group.data[5:0];
            default:           sextet = r_group.data[5:0];
        endcase
    end

    assign is_pad = (r_pos == b64enc_pkg::POS_3 && r_group.pads != b64enc_pkg::PAD_NONE)
                 || (r_pos == b64enc_pkg::POS_2 && r_group.pads == b64enc_pkg::PAD_TWO);
    assign next_char = is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_to_char(sextet);

    always_ff @(posedge i_clk) begin
        if (o_queue_pop) begin
            r_group <= i_head;
        end
        if (out_load) begin
            r_char <= next_char;
            r_eom  <= r_group.last && (r_pos == b64enc_pkg::POS_3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= b64enc_pkg::POS_0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_queue_pop) begin
                r_busy <= 1'b1;
                r_pos  <= b64enc_pkg::POS_0;
            end else if (group_done) begin
                r_busy <= 1'b0;
                r_pos  <= b64enc_pkg::POS_0;
            end else if (out_load) begin
                r_pos <= b64enc_pkg::t_pos'(r_pos + 2'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_out_char       = r_char;
    assign o_end_of_message = r_eom;

`ifndef SYNTH
    a_take_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_queue_pop |-> (!r_busy || group_done))
        else $error("group taken while the previous one is unfinished");

    a_idle_after_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (group_done && !o_queue_pop) |=> !r_busy)
        else $error("serialiser still busy after its fourth character");

    a_no_early_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_pos == b64enc_pkg::POS_0 || r_pos == b64enc_pkg::POS_1))
            |-> next_char != b64enc_pkg::PAD_CHAR)
        else $error("pad character in the first half of a group");

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pos == b64enc_pkg::POS_0)
        else $error("character position not rewound while idle");
`endif

endmodule

// File: hw/rtl/base64_stream_encoder.sv
// Top level of the base64 stream encoder: byte gatherer, group queue and
// character serialiser. Depends on b64enc_pkg and the three b64enc modules.
//
// Usage. Message bytes come in on a queue-style input: a transfer happens at a
// rising edge with i_push high and o_full low, carrying i_data_byte and
// i_final_byte, the latter set on the last byte of a message. Encoded
// characters leave on a queue-style output: while o_empty is low, o_out_char
// holds the oldest waiting character and o_end_of_message marks the final
// character of a message; a transfer happens at an edge with i_pop high.
// Every third byte, and every flagged byte, yields one group of four
// characters; a short final group is zero-filled and ends in '=' padding.
// When the serialiser is idle, a group whose last byte is transferred passes
// from the queue into its group register, then its first character into the
// output register. Throughput: the serialiser sends one character per cycle
// while the receiver keeps taking them, and input can be taken every cycle
// while the group queue has room; on long messages the serialiser sets the pace.
// When the receiver stalls, the output register holds its character, the
// serialiser waits, groups collect in the queue (QUEUE_DEPTH entries), and
// o_full rises once the queue is full. The gatherer stalls only then.
// Synchronous active-low reset empties the queue, the output register and
// the pending-byte buffer, so the next byte starts a new message.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_char,
    output logic        o_end_of_message
);

    b64enc_pkg::t_group front_group;
    b64enc_pkg::t_group queue_head;
    logic               queue_push;
    logic               queue_pop;
    logic               queue_full;
    logic               queue_empty;

    // The input side is full exactly when the group queue is full.
    assign o_full = queue_full;

    b64enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_queue_full (queue_full),
        .o_queue_push (queue_push),
        .o_group      (front_group)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_group (front_group),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (queue_head)
    );

    b64enc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_queue_empty    (queue_empty),
        .i_head           (queue_head),
        .o_queue_pop      (queue_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_out_char       (o_out_char),
        .o_end_of_message (o_end_of_message)
    );

endmodule

// File: test/b64enc_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the base64 stream encoder testbench: predicts the characters that
// each transferred byte gives and checks the character stream against them.
// Depends on b64enc_pkg for the pad count type and the pad character.
package b64enc_tb_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } t_b64_char;

    class b64_scoreboard;
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        t_b64_char   awaited_chars[$];
        int unsigned fail_count;

        function new();
            held_bytes = '0;
            held_count = '0;
            fail_count = 0;
        endfunction

        // Gathers the byte; a third byte or a flagged one yields four characters.
        function void note_byte(input logic [7:0] b, input logic fin);
            string              alphabet;
            logic [23:0]        group;
            b64enc_pkg::t_pads  pads;
            t_b64_char          c;
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            if (!fin && held_count < 2'd2) begin
                if (held_count == 2'd0) begin
                    held_bytes = {b, 8'h00};
                end else begin
                    held_bytes[7:0] = b;
                end
                held_count = held_count + 2'd1;
                return;
            end
            case (held_count)
                2'd2: begin
                    group = {held_bytes, b};
                    pads  = b64enc_pkg::PAD_NONE;
                end
                2'd1: begin
                    group = {held_bytes[15:8], b, 8'h00};
                    pads  = b64enc_pkg::PAD_ONE;
                end
                default: begin
                    group = {b, 16'h0000};
                    pads  = b64enc_pkg::PAD_TWO;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                if (k >= 4 - int'(pads)) begin
                    c.ch = b64enc_pkg::PAD_CHAR;
                end else begin
                    c.ch = alphabet[group[23 - 6 * k -: 6]];
                end
                c.eom = fin && (k == 3);
                awaited_chars.push_back(c);
            end
            held_bytes = '0;
            held_count = '0;
        endfunction

        function void check_char(input logic [7:0] ch, input logic eom);
            t_b64_char want;
            if (awaited_chars.size() == 0) begin
                fail_count++;
                $display("%0t: character with none awaited: expected none, actual %h eom %b",
                         $time, ch, eom);
                return;
            end
            want = awaited_chars.pop_front();
            if (want.ch !== ch) begin
                fail_count++;
                $display("%0t: out_char mismatch: expected %h, actual %h",
                         $time, want.ch, ch);
            end
            if (want.eom !== eom) begin
                fail_count++;
                $display("%0t: end_of_message mismatch: expected %b, actual %b",
                         $time, want.eom, eom);
            end
        endfunction

        function int unsigned outstanding();
            return awaited_chars.size();
        endfunction
    endclass

endpackage

// File: test/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps
// Top level of the base64 stream encoder testbench: clock, reset, byte sender,
// character receiver and watchdog around one encoder instance.
// Depends on b64enc_pkg, b64enc_tb_pkg and the encoder RTL.
module base64_stream_encoder_tb;

    // Quiet cycles (no transfer on either side) after which the run is abandoned.
    // Gaps and stalls are random with at most 47 in a hundred, so a stretch of a
    // few dozen quiet cycles is already very unlikely in a correct run.
    localparam int unsigned QUIET_LIMIT = 2000;

    // Idling per phase: none, sender idle, receiver stalling, both a little.
    localparam int unsigned PUSH_IDLE_PCT [4] = '{0, 47, 0, 15};
    localparam int unsigned POP_STALL_PCT [4] = '{0, 0, 47, 15};

    // Opening messages, bit 8 being the end-of-message flag. They cover a lone
    // byte at both extremes (two pad characters), a two-byte message (one pad),
    // all-ones giving '/' and a pattern giving '+', a message of two whole groups,
    // and a whole group followed by a lone final byte.
    localparam logic [8:0] OPENING_BYTES [20] = '{
        9'h100, 9'h1FF, 9'h000, 9'h1FF, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h0FB, 9'h0EF, 9'h1BE, 9'h000, 9'h010, 9'h083, 9'h010,
        9'h051, 9'h187, 9'h04D, 9'h061, 9'h06E, 9'h14D
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_pop = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [7:0] o_out_char;
    logic       o_end_of_message;

    int unsigned push_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    b64enc_tb_pkg::b64_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    base64_stream_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_byte      (i_data_byte),
        .i_final_byte     (i_final_byte),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_out_char       (o_out_char),
        .o_end_of_message (o_end_of_message)
    );

    // The receiver decides at each falling edge whether it will take a
    // character at the next rising edge. It stays quiet during reset.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Every character transfer is checked against the oldest prediction. The
    // values are read at the rising edge, before the block updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            sb.check_char(o_out_char, o_end_of_message);
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offers one byte, after a random number of idle cycles, and holds it until
    // the transfer happens. Called and left at a falling edge; push is assigned
    // only once per falling edge, so a byte that follows straight on keeps push
    // high without a glitch.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < push_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push       <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
        sb.note_byte(b, fin);
        @(negedge i_clk);
    endtask

    // A message of random bytes with the flag on its last byte.
    task automatic send_message(input int unsigned len);
        for (int unsigned n = 0; n < len; n++) begin
            send_byte(8'($urandom_range(255)), n == len - 1);
        end
    endtask

    // The sender stands back until every predicted character has been taken.
    // The extra falling edge keeps push to one assignment per time step.
    task automatic hold_until_drained();
        i_push <= 1'b0;
        @(negedge i_clk);
        while (sb.outstanding() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int unsigned phase_bytes;
        int unsigned len;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed messages with no idling on either side.
        foreach (OPENING_BYTES[n]) begin
            send_byte(OPENING_BYTES[n][7:0], OPENING_BYTES[n][8]);
        end
        hold_until_drained();

        // Random messages, mostly short so that every padding case recurs
        // often, with the odd long one to run many whole groups back to back.
        for (int p = 0; p < 4; p++) begin
            push_idle_pct = PUSH_IDLE_PCT[p];
            pop_stall_pct = POP_STALL_PCT[p];
            phase_bytes = 0;
            while (phase_bytes < 70) begin
                if ($urandom_range(9) == 0) begin
                    len = $urandom_range(40, 10);
                end else begin
                    len = $urandom_range(6, 1);
                end
                send_message(len);
                phase_bytes += len;
            end
            hold_until_drained();
        end

        // A short tail in which any stray character would still be caught.
        repeat (10) @(negedge i_clk);

        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder.sv
test/b64enc_tb_pkg.sv
test/base64_stream_encoder_tb.sv
